/* sv/rsub_pkg.sv */
// Package for rectangle_subtract: piece slot codes and bank depth.
package rsub_pkg;

    // Slots of the piece bank, in emission order
    typedef enum logic [1:0] {
        PC_LEFT  = 2'd0,
        PC_LOW   = 2'd1,
        PC_HIGH  = 2'd2,
        PC_RIGHT = 2'd3
    } piece_t;

    localparam int NUM_PIECES = 4;

endpackage

/* sv/rectangle_subtract.sv */
// Axis-aligned rectangle subtraction: emits the parts of A not covered by B.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------------
//  command  | start in, busy out      | a_x a_y a_w a_h b_x b_y b_w b_h
//  pieces   | piece_valid out, strobe | piece_x piece_y piece_w piece_h last_piece
//
// A command transfers at a rising edge with start high and busy low. It sits in the
// input register, is cut combinationally into up to four pieces and lands in a piece bank,
// which shifts one piece a cycle into the output register. The bank reloads in the
// cycle its last piece leaves, or at once when empty, so a new command can wait in the
// input register while the pieces of the one before are still leaving.
// Each piece is on the ports for one cycle only; the receiver cannot stall.
// Reset clears the valid flags and the bank mask; payload registers are not reset.
module rectangle_subtract #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic        [COORD_BITS-2:0] a_w,
    input  logic        [COORD_BITS-2:0] a_h,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic        [COORD_BITS-2:0] b_w,
    input  logic        [COORD_BITS-2:0] b_h,
    output logic                         piece_valid,
    output logic signed [COORD_BITS-1:0] piece_x,
    output logic signed [COORD_BITS-1:0] piece_y,
    output logic        [COORD_BITS-2:0] piece_w,
    output logic        [COORD_BITS-2:0] piece_h,
    output logic                         last_piece
);

    localparam int N  = COORD_BITS;
    localparam int E  = COORD_BITS + 2;
    localparam int NP = rsub_pkg::NUM_PIECES;
    localparam logic signed [E-1:0] ONE_E  = 1;
    localparam logic signed [E-1:0] ZERO_E = 0;

    // Input register
    logic                in_valid_reg, in_valid_next;
    logic signed [N-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic        [N-2:0] aw_reg, ah_reg, bw_reg, bh_reg;

    // Piece bank
    logic [NP-1:0]       mask_reg, mask_next;
    logic signed [N-1:0] bank_x_reg [NP];
    logic signed [N-1:0] bank_y_reg [NP];
    logic        [N-2:0] bank_w_reg [NP];
    logic        [N-2:0] bank_h_reg [NP];

    // Output register
    logic                piece_valid_reg, piece_valid_next;
    logic signed [N-1:0] piece_x_reg;
    logic signed [N-1:0] piece_y_reg;
    logic        [N-2:0] piece_w_reg;
    logic        [N-2:0] piece_h_reg;
    logic                last_reg;

    logic accept;
    logic load;

    // Extended edges
    logic signed [E-1:0] ax0, ay0, aw_e, ah_e, ax1, ay1;
    logic signed [E-1:0] bx0, by0, bx1, by1;
    logic signed [E-1:0] cx0, cy0, cx1, cy1;
    logic                a_empty, b_empty, b_miss;
    logic signed [E-1:0] cut_x [NP];
    logic signed [E-1:0] cut_y [NP];
    logic signed [E-1:0] cut_w [NP];
    logic signed [E-1:0] cut_h [NP];
    logic [NP-1:0]       new_mask;

    rsub_pkg::piece_t    pop_idx;
    logic [NP-1:0]       rest_mask;

    // Cut the registered command into pieces
    always_comb
    begin
        ax0  = $signed({{2{ax_reg[N-1]}}, ax_reg});
        ay0  = $signed({{2{ay_reg[N-1]}}, ay_reg});
        bx0  = $signed({{2{bx_reg[N-1]}}, bx_reg});
        by0  = $signed({{2{by_reg[N-1]}}, by_reg});
        aw_e = $signed({3'b000, aw_reg});
        ah_e = $signed({3'b000, ah_reg});
        ax1  = ax0 + aw_e - ONE_E;
        ay1  = ay0 + ah_e - ONE_E;
        bx1  = bx0 + $signed({3'b000, bw_reg}) - ONE_E;
        by1  = by0 + $signed({3'b000, bh_reg}) - ONE_E;
        cx0  = (ax0 > bx0) ? ax0 : bx0;
        cy0  = (ay0 > by0) ? ay0 : by0;
        cx1  = (ax1 < bx1) ? ax1 : bx1;
        cy1  = (ay1 < by1) ? ay1 : by1;

        a_empty = (aw_reg == '0) || (ah_reg == '0);
        b_empty = (bw_reg == '0) || (bh_reg == '0);
        b_miss  = (cx0 > cx1) || (cy0 > cy1);

        cut_x[rsub_pkg::PC_LEFT]  = ax0;
        cut_y[rsub_pkg::PC_LEFT]  = ay0;
        cut_w[rsub_pkg::PC_LEFT]  = cx0 - ax0;
        cut_h[rsub_pkg::PC_LEFT]  = ah_e;
        cut_x[rsub_pkg::PC_LOW]   = cx0;
        cut_y[rsub_pkg::PC_LOW]   = ay0;
        cut_w[rsub_pkg::PC_LOW]   = ax1 - cx0 + ONE_E;
        cut_h[rsub_pkg::PC_LOW]   = cy0 - ay0;
        cut_x[rsub_pkg::PC_HIGH]  = cx0;
        cut_y[rsub_pkg::PC_HIGH]  = cy1 + ONE_E;
        cut_w[rsub_pkg::PC_HIGH]  = ax1 - cx0 + ONE_E;
        cut_h[rsub_pkg::PC_HIGH]  = ay1 - cy1;
        cut_x[rsub_pkg::PC_RIGHT] = cx1 + ONE_E;
        cut_y[rsub_pkg::PC_RIGHT] = cy0;
        cut_w[rsub_pkg::PC_RIGHT] = ax1 - cx1;
        cut_h[rsub_pkg::PC_RIGHT] = cy1 - cy0 + ONE_E;

        for (int i = 0; i < NP; i++)
        begin
            new_mask[i] = (cut_w[i] > ZERO_E) && (cut_h[i] > ZERO_E);
        end

        // Pass A through whole when B is empty or misses it
        if (b_empty || b_miss)
        begin
            cut_w[rsub_pkg::PC_LEFT] = aw_e;
            new_mask                 = '0;
            new_mask[rsub_pkg::PC_LEFT] = 1'b1;
        end
        if (a_empty)
        begin
            new_mask = '0;
        end
    end

    // Pick the lowest pending piece and what stays behind
    always_comb
    begin
        pop_idx = rsub_pkg::PC_LEFT;
        for (int i = NP - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pop_idx = rsub_pkg::piece_t'(i);
            end
        end
        rest_mask          = mask_reg;
        rest_mask[pop_idx] = 1'b0;
    end

    // Handshake and next-state control
    always_comb
    begin
        load             = in_valid_reg && (rest_mask == '0);
        busy             = in_valid_reg && !load;
        accept           = start && !busy;
        in_valid_next    = accept || (in_valid_reg && !load);
        mask_next        = load ? new_mask : rest_mask;
        piece_valid_next = (mask_reg != '0);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            mask_reg        <= '0;
            piece_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg    <= in_valid_next;
            mask_reg        <= mask_next;
            piece_valid_reg <= piece_valid_next;
        end
    end

    // Capture the command on transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg <= a_x;
            ay_reg <= a_y;
            aw_reg <= a_w;
            ah_reg <= a_h;
            bx_reg <= b_x;
            by_reg <= b_y;
            bw_reg <= b_w;
            bh_reg <= b_h;
        end
    end

    // Load the bank with the cut pieces, truncated to field widths
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NP; i++)
            begin
                bank_x_reg[i] <= cut_x[i][N-1:0];
                bank_y_reg[i] <= cut_y[i][N-1:0];
                bank_w_reg[i] <= cut_w[i][N-2:0];
                bank_h_reg[i] <= cut_h[i][N-2:0];
            end
        end
    end

    // Advance one piece into the output register
    always_ff @(posedge clk)
    begin
        if (mask_reg != '0)
        begin
            piece_x_reg <= bank_x_reg[pop_idx];
            piece_y_reg <= bank_y_reg[pop_idx];
            piece_w_reg <= bank_w_reg[pop_idx];
            piece_h_reg <= bank_h_reg[pop_idx];
            last_reg    <= (rest_mask == '0);
        end
    end

    assign piece_valid = piece_valid_reg;
    assign piece_x     = piece_x_reg;
    assign piece_y     = piece_y_reg;
    assign piece_w     = piece_w_reg;
    assign piece_h     = piece_h_reg;
    assign last_piece  = last_reg;

    // Pieces of one command leave back to back
    a_pieces_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid && !last_piece |=> piece_valid)
        else $error("piece stream broke before last piece");

    // Every emitted piece is non-empty
    a_piece_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        piece_valid |-> (piece_w != '0) && (piece_h != '0))
        else $error("empty piece emitted");

    // A held command waits while more than one piece is pending
    a_hold_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && ($countones(mask_reg) > 1) |-> busy)
        else $error("bank reloaded while pieces pending");

    // A blocked start leaves the held command untouched
    a_blocked_start: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> $stable(ax_reg) && $stable(bx_reg) && $stable(aw_reg) && $stable(bw_reg))
        else $error("command register changed while busy");

endmodule

/* tb/rectangle_subtract_test.sv */
// Self-checking testbench for rectangle_subtract: directed corner cases and random rectangles.
module rectangle_subtract_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 16;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic        [CW-2:0] aw;
        logic        [CW-2:0] ah;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic        [CW-2:0] bw;
        logic        [CW-2:0] bh;
    } cmd_t;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic        [CW-2:0] w;
        logic        [CW-2:0] h;
        logic                 is_last;
    } piece_rec_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic        [CW-2:0] a_w;
    logic        [CW-2:0] a_h;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic        [CW-2:0] b_w;
    logic        [CW-2:0] b_h;
    logic                 piece_valid;
    logic signed [CW-1:0] piece_x;
    logic signed [CW-1:0] piece_y;
    logic        [CW-2:0] piece_w;
    logic        [CW-2:0] piece_h;
    logic                 last_piece;

    piece_rec_t pending_pieces[$];
    piece_rec_t want;
    int         mismatch_count = 0;
    int         idle_pct = 0;

    rectangle_subtract #(
        .COORD_BITS(CW)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .a_x(a_x),
        .a_y(a_y),
        .a_w(a_w),
        .a_h(a_h),
        .b_x(b_x),
        .b_y(b_y),
        .b_w(b_w),
        .b_h(b_h),
        .piece_valid(piece_valid),
        .piece_x(piece_x),
        .piece_y(piece_y),
        .piece_w(piece_w),
        .piece_h(piece_h),
        .last_piece(last_piece)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Append one piece unless it is empty; corners wrap to the coordinate width
    function automatic void add_piece(ref piece_rec_t found[$],
                                      input longint x, input longint y,
                                      input longint w, input longint h);
        piece_rec_t p;
        if (w <= 0 || h <= 0)
            return;
        p.x = x[CW-1:0];
        p.y = y[CW-1:0];
        p.w = w[CW-2:0];
        p.h = h[CW-2:0];
        p.is_last = 1'b0;
        found.push_back(p);
    endfunction

    // Cut A by B and queue the pieces that should come out
    function automatic void cut_command(input cmd_t c);
        longint     ax0, ay0, aw, ah, ax1, ay1;
        longint     bx0, by0, bw, bh;
        longint     cx0, cy0, cx1, cy1;
        piece_rec_t found[$];
        ax0 = longint'(c.ax);
        ay0 = longint'(c.ay);
        aw  = longint'(c.aw);
        ah  = longint'(c.ah);
        bx0 = longint'(c.bx);
        by0 = longint'(c.by);
        bw  = longint'(c.bw);
        bh  = longint'(c.bh);
        if (aw == 0 || ah == 0)
            return;
        ax1 = ax0 + aw - 1;
        ay1 = ay0 + ah - 1;
        if (bw == 0 || bh == 0)
        begin
            add_piece(found, ax0, ay0, aw, ah);
        end
        else
        begin
            cx0 = (ax0 > bx0) ? ax0 : bx0;
            cy0 = (ay0 > by0) ? ay0 : by0;
            cx1 = (ax1 < bx0 + bw - 1) ? ax1 : bx0 + bw - 1;
            cy1 = (ay1 < by0 + bh - 1) ? ay1 : by0 + bh - 1;
            if (cx0 > cx1 || cy0 > cy1)
            begin
                add_piece(found, ax0, ay0, aw, ah);
            end
            else
            begin
                // left, low, high, right strips in that order
                add_piece(found, ax0, ay0, cx0 - ax0, ah);
                add_piece(found, cx0, ay0, ax1 - cx0 + 1, cy0 - ay0);
                add_piece(found, cx0, cy1 + 1, ax1 - cx0 + 1, ay1 - cy1);
                add_piece(found, cx1 + 1, cy0, ax1 - cx1, cy1 - cy0 + 1);
            end
        end
        if (found.size() > 0)
            found[found.size() - 1].is_last = 1'b1;
        foreach (found[i])
            pending_pieces.push_back(found[i]);
    endfunction

    function automatic cmd_t mk(input int ax, input int ay, input int aw, input int ah,
                                input int bx, input int by, input int bw, input int bh);
        cmd_t c;
        c.ax = CW'(ax);
        c.ay = CW'(ay);
        c.aw = (CW-1)'(aw);
        c.ah = (CW-1)'(ah);
        c.bx = CW'(bx);
        c.by = CW'(by);
        c.bw = (CW-1)'(bw);
        c.bh = (CW-1)'(bh);
        return c;
    endfunction

    // Mostly small sizes, now and then empty or huge
    function automatic int pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return 0;
        else if (roll < 75)
            return $urandom_range(1, 16);
        else if (roll < 95)
            return $urandom_range(1, 512);
        return $urandom_range(0, 32767);
    endfunction

    // B placed around A so that most commands overlap; some are pure noise
    function automatic cmd_t random_cmd();
        cmd_t c;
        int   span;
        if ($urandom_range(99) < 20)
        begin
            c = mk($urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
        end
        else
        begin
            c.ax = CW'($urandom);
            c.ay = CW'($urandom);
            c.aw = (CW-1)'(pick_size());
            c.ah = (CW-1)'(pick_size());
            c.bw = (CW-1)'(pick_size());
            c.bh = (CW-1)'(pick_size());
            span = int'(c.aw) + int'(c.bw) + 1;
            c.bx = CW'(int'(c.ax) - int'(c.bw) + int'($urandom_range(0, span)));
            span = int'(c.ah) + int'(c.bh) + 1;
            c.by = CW'(int'(c.ay) - int'(c.bh) + int'($urandom_range(0, span)));
        end
        return c;
    endfunction

    // Transfer one command; idle the sender cycle by cycle at the phase's rate first
    task automatic send_cmd(input cmd_t c);
        @(negedge clk);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        a_x = c.ax;
        a_y = c.ay;
        a_w = c.aw;
        a_h = c.ah;
        b_x = c.bx;
        b_y = c.by;
        b_w = c.bw;
        b_h = c.bh;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        cut_command(c);
    endtask

    // Hold off until every queued piece has arrived and the block is quiet
    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (pending_pieces.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_cmd(random_cmd());
    endtask

    task automatic test_special_cases();
        idle_pct = 0;
        // empty A
        send_cmd(mk(10, 20, 0, 5, 10, 20, 3, 3));
        send_cmd(mk(-5, -5, 7, 0, -32768, -32768, 32767, 32767));
        wait_drained();
        // empty B
        send_cmd(mk(100, -200, 30, 40, 110, -190, 0, 5));
        send_cmd(mk(100, -200, 30, 40, 110, -190, 5, 0));
        // B misses A: far left, just above, just right
        send_cmd(mk(0, 0, 10, 10, -20, 0, 5, 5));
        send_cmd(mk(0, 0, 10, 10, 0, 10, 10, 10));
        send_cmd(mk(0, 0, 10, 10, 10, 0, 1, 10));
        // B covers A exactly and with margin
        send_cmd(mk(5, 5, 8, 8, 5, 5, 8, 8));
        send_cmd(mk(5, 5, 8, 8, -100, -100, 1000, 1000));
        // B strictly inside: all four strips
        send_cmd(mk(0, 0, 10, 10, 3, 4, 2, 3));
        send_cmd(mk(-10, -10, 3, 3, -9, -9, 1, 1));
        // B flush with the left, low, high and right edges
        send_cmd(mk(0, 0, 10, 10, -5, 2, 8, 3));
        send_cmd(mk(0, 0, 10, 10, 4, -5, 3, 8));
        send_cmd(mk(0, 0, 10, 10, 4, 7, 3, 8));
        send_cmd(mk(0, 0, 10, 10, 7, 2, 8, 3));
        // B over the low-left corner
        send_cmd(mk(0, 0, 10, 10, -2, -2, 5, 5));
        // pieces past the top coordinate wrap
        send_cmd(mk(32760, 32760, 32767, 32767, 32767, 32767, 1, 1));
        send_cmd(mk(32000, 32000, 32767, 32767, 32700, 32700, 10, 10));
        // extremes of the low corner and of the sizes
        send_cmd(mk(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
        send_cmd(mk(-32768, -32768, 32767, 32767, -1, -1, 32767, 32767));
        send_cmd(mk(-1, -1, 32767, 32767, -32768, -32768, 32767, 32767));
        wait_drained();
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        run_random(140);
        wait_drained();
    endtask

    task automatic test_sender_gaps();
        idle_pct = 69;
        run_random(140);
        wait_drained();
    endtask

    task automatic test_mixed_gaps();
        idle_pct = 36;
        run_random(140);
        wait_drained();
    endtask

    // Compare each piece with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && piece_valid)
        begin
            if (pending_pieces.size() == 0)
            begin
                $error("unexpected piece x=%0d y=%0d w=%0d h=%0d",
                       piece_x, piece_y, piece_w, piece_h);
                mismatch_count++;
            end
            else
            begin
                want = pending_pieces.pop_front();
                if (piece_x !== want.x)
                begin
                    $error("piece_x expected %0d got %0d", want.x, piece_x);
                    mismatch_count++;
                end
                if (piece_y !== want.y)
                begin
                    $error("piece_y expected %0d got %0d", want.y, piece_y);
                    mismatch_count++;
                end
                if (piece_w !== want.w)
                begin
                    $error("piece_w expected %0d got %0d", want.w, piece_w);
                    mismatch_count++;
                end
                if (piece_h !== want.h)
                begin
                    $error("piece_h expected %0d got %0d", want.h, piece_h);
                    mismatch_count++;
                end
                if (last_piece !== want.is_last)
                begin
                    $error("last_piece expected %0d got %0d", want.is_last, last_piece);
                    mismatch_count++;
                end
            end
        end
    end

    // Bound the run
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        a_x = '0;
        a_y = '0;
        a_w = '0;
        a_h = '0;
        b_x = '0;
        b_y = '0;
        b_w = '0;
        b_h = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_special_cases();
        test_back_to_back();
        test_sender_gaps();
        test_mixed_gaps();

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/rsub_pkg.sv
sv/rectangle_subtract.sv
tb/rectangle_subtract_test.sv
